### design/xsr_pkg.sv
// Shared constants, types and helper functions for the xoshiro256++ random source.
`default_nettype none

package xsr_pkg;

  localparam int RESULT_BITS_DEFAULT = 62;
  localparam int FRAC_BITS           = 53;
  localparam int WORD_BITS           = 64;
  localparam int NUM_WORDS           = 4;

  // Request codes carried in the func field
  localparam logic [1:0] FUNC_SEED    = 2'd0;
  localparam logic [1:0] FUNC_BOUNDED = 2'd1;
  localparam logic [1:0] FUNC_UNIT    = 2'd2;

  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  localparam int ROT_DRAW  = 23;
  localparam int ROT_STATE = 45;
  localparam int SHL_STATE = 17;

  // Request to and answer from the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int amt);
    logic [127:0] dbl;
    dbl = {v, v} << amt;
    return dbl[127:64];
  endfunction

  // Full SplitMix64 output mix; evaluated on constants only (reset values)
  function automatic logic [63:0] sm64_mix(input logic [63:0] acc);
    logic [63:0] z;
    z = acc;
    z = 64'((z ^ (z >> 30)) * MIX_MUL_A);
    z = 64'((z ^ (z >> 27)) * MIX_MUL_B);
    return z ^ (z >> 31);
  endfunction

  // State after reset: expansion of seed zero
  localparam logic [63:0] RESET_W0 = sm64_mix(64'(GOLDEN_INC * 64'd1));
  localparam logic [63:0] RESET_W1 = sm64_mix(64'(GOLDEN_INC * 64'd2));
  localparam logic [63:0] RESET_W2 = sm64_mix(64'(GOLDEN_INC * 64'd3));
  localparam logic [63:0] RESET_W3 = sm64_mix(64'(GOLDEN_INC * 64'd4));

endpackage

`default_nettype wire

### design/xsr_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface xsr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [63:0] operand;

  modport source (output valid, func, operand, input ready);
  modport sink   (input valid, func, operand, output ready);
endinterface

interface xsr_out_if import xsr_pkg::*; #(
  parameter int RESULT_BITS = RESULT_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [RESULT_BITS-1:0] int_value;
  logic [FRAC_BITS-1:0]   unit_fraction;

  modport source (output valid, int_value, unit_fraction, input ready);
  modport sink   (input valid, int_value, unit_fraction, output ready);
endinterface

`default_nettype wire

### design/xsr_mul_unit.sv
// Low 64 bits of a 64x64 product, built from one 32x32 multiplier.
`default_nettype none

module xsr_mul_unit import xsr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] acc;
  logic [1:0]  phase;
  logic        busy;
  logic        done;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] partial;

  // phase 0: aL*bL, phase 1: aL*bH << 32, phase 2: aH*bL << 32
  always_comb begin
    mul_x = op_a[31:0];
    mul_y = op_b[31:0];
    case (phase)
      2'd1: mul_y = op_b[63:32];
      2'd2: mul_x = op_a[63:32];
      default: ;
    endcase
    partial = 64'(mul_x) * 64'(mul_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        if (phase == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op_a <= req.a;
      op_b <= req.b;
    end
    if (busy) begin
      if (phase == 2'd0) begin
        acc <= partial;
      end else begin
        acc <= acc + {partial[31:0], 32'd0};
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

`default_nettype wire

### design/xoshiro256pp_random_source_core.sv
// Top level: xoshiro256++ generator with SplitMix64 seeding, bounded and unit draws.
//
// One request is taken at a time; in_ch.ready is high only while the sequencer is
// idle, and a finished result sits in the output register so the next request can
// be taken before it is collected. A unit draw or a draw with a bound of zero or
// less passes through the advance and done states to the output register. A draw
// with a positive bound also passes through the divide state, where a restoring
// divider forms the remainder one bit per cycle. A seed request fills the four
// SplitMix64 words in turn: each needs two 64-bit products, and both go through
// one shared 32x32 multiplier. The reset state is the expansion of seed zero.
`default_nettype none

module xoshiro256pp_random_source_core import xsr_pkg::*; #(
  parameter int RESULT_BITS = RESULT_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  xsr_in_if.sink     in_ch,
  xsr_out_if.source  out_ch
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_ADVANCE   = 7'b0000010,
    ST_DIVIDE    = 7'b0000100,
    ST_SEED_ADD  = 7'b0001000,
    ST_SEED_MULA = 7'b0010000,
    ST_SEED_MULB = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  state_t state;

  logic [63:0] gen_words [NUM_WORDS];
  logic [1:0]  func;
  logic [63:0] bound;
  logic [63:0] sum_ad;
  logic [63:0] dividend;
  logic [63:0] rem;
  logic [5:0]  bit_cnt;
  logic [63:0] seed_acc;
  logic [63:0] z;
  logic [1:0]  word_idx;
  logic        mul_go;
  logic        seed_fix;

  logic [RESULT_BITS-1:0] res_int;
  logic [FRAC_BITS-1:0]   res_frac;
  logic                   out_valid;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic        in_xfer;
  logic        bound_pos;
  logic [63:0] draw;
  logic [63:0] nxt_a, nxt_b, nxt_c, nxt_d;
  logic [63:0] rem_sh;
  logic        rem_ge;
  logic [63:0] rem_new;
  logic [63:0] seed_sum;
  logic [63:0] prod_sh27;
  logic [63:0] prod_sh31;
  logic        out_free;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign bound_pos   = !bound[63] && (bound != 64'd0);
  assign out_free    = !out_valid || out_ch.ready;

  // Generator step
  always_comb begin
    logic [63:0] c1, d1;
    draw  = rotl64(sum_ad, ROT_DRAW) + gen_words[0];
    c1    = gen_words[2] ^ gen_words[0];
    d1    = gen_words[3] ^ gen_words[1];
    nxt_b = gen_words[1] ^ c1;
    nxt_a = gen_words[0] ^ d1;
    nxt_c = c1 ^ (gen_words[1] << SHL_STATE);
    nxt_d = rotl64(d1, ROT_STATE);
  end

  // Restoring remainder step; rem < bound < 2^63 so the shift drops nothing
  assign rem_sh  = {rem[62:0], dividend[63]};
  assign rem_ge  = (rem_sh >= bound);
  assign rem_new = rem_ge ? (rem_sh - bound) : rem_sh;

  assign seed_sum  = seed_acc + GOLDEN_INC;
  assign prod_sh27 = mul_rsp.product ^ (mul_rsp.product >> 27);
  assign prod_sh31 = mul_rsp.product ^ (mul_rsp.product >> 31);

  assign mul_req.start = mul_go;
  assign mul_req.a     = z;
  assign mul_req.b     = (state == ST_SEED_MULB) ? MIX_MUL_B : MIX_MUL_A;

  xsr_mul_unit u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mul_go       <= 1'b0;
      seed_fix     <= 1'b0;
      gen_words[0] <= RESET_W0;
      gen_words[1] <= RESET_W1;
      gen_words[2] <= RESET_W2;
      gen_words[3] <= RESET_W3;
    end else begin
      mul_go   <= 1'b0;
      seed_fix <= 1'b0;
      // all-zero expansion: word 0 becomes 1
      if (seed_fix && ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 64'd0)) begin
        gen_words[0] <= 64'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (in_ch.func)
              FUNC_SEED: state <= ST_SEED_ADD;
              FUNC_BOUNDED, FUNC_UNIT: state <= ST_ADVANCE;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_ADVANCE: begin
          gen_words[0] <= nxt_a;
          gen_words[1] <= nxt_b;
          gen_words[2] <= nxt_c;
          gen_words[3] <= nxt_d;
          if (func == FUNC_BOUNDED && bound_pos) begin
            state <= ST_DIVIDE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIVIDE: begin
          if (bit_cnt == 6'd0) begin
            state <= ST_DONE;
          end
        end
        ST_SEED_ADD: begin
          mul_go <= 1'b1;
          state  <= ST_SEED_MULA;
        end
        ST_SEED_MULA: begin
          if (mul_rsp.done) begin
            mul_go <= 1'b1;
            state  <= ST_SEED_MULB;
          end
        end
        ST_SEED_MULB: begin
          if (mul_rsp.done) begin
            gen_words[word_idx] <= prod_sh31;
            if (word_idx == 2'd3) begin
              seed_fix <= 1'b1;
              state    <= ST_IDLE;
            end else begin
              state <= ST_SEED_ADD;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          func     <= in_ch.func;
          bound    <= in_ch.operand;
          sum_ad   <= gen_words[0] + gen_words[3];
          seed_acc <= in_ch.operand;
          word_idx <= 2'd0;
        end
      end
      ST_ADVANCE: begin
        rem      <= 64'd0;
        dividend <= draw;
        bit_cnt  <= 6'd63;
        if (func == FUNC_UNIT) begin
          res_int  <= '0;
          res_frac <= draw[63:11];
        end else begin
          res_int  <= draw[RESULT_BITS-1:0];
          res_frac <= '0;
        end
      end
      ST_DIVIDE: begin
        rem      <= rem_new;
        dividend <= {dividend[62:0], 1'b0};
        bit_cnt  <= bit_cnt - 6'd1;
        if (bit_cnt == 6'd0) begin
          res_int <= rem_new[RESULT_BITS-1:0];
        end
      end
      ST_SEED_ADD: begin
        seed_acc <= seed_sum;
        z        <= seed_sum ^ (seed_sum >> 30);
      end
      ST_SEED_MULA: begin
        if (mul_rsp.done) begin
          z <= prod_sh27;
        end
      end
      ST_SEED_MULB: begin
        if (mul_rsp.done) begin
          word_idx <= word_idx + 2'd1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_ch.int_value     <= res_int;
      out_ch.unit_fraction <= res_frac;
    end
  end

  assign out_ch.valid = out_valid;

  // Multiplier answers only arrive while seeding
  a_mul_done_in_seed: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == ST_SEED_MULA || state == ST_SEED_MULB))
    else $error("multiplier done outside seeding");

  // Remainder stays below the bound throughout the divide state
  a_rem_below_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < bound))
    else $error("remainder not below bound");

  // Seeding never leaves an all-zero state
  a_seed_nonzero: assert property (@(posedge clk) disable iff (rst)
    seed_fix |=> ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) != 64'd0))
    else $error("all-zero state after seeding");

  // A result carries either an integer or a fraction, never both
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ch.int_value == '0 || out_ch.unit_fraction == '0))
    else $error("both result fields nonzero");

  // No request is taken in a cycle that starts a seed product on the multiplier
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    mul_go |-> !in_ch.ready)
    else $error("ready while seeding");

endmodule

`default_nettype wire
